### rtl/core/aes_pkg.sv
// Package with AES-256 constants, types and byte-level functions.
package aes_pkg;
	localparam int NUM_ROUNDS = 14;
	localparam int STORE_DEPTH = 2 * (NUM_ROUNDS + 1);
	localparam int ADDR_W = $clog2(STORE_DEPTH);
	localparam int RND_W = $clog2(NUM_ROUNDS + 1);
	localparam int CFG_IDX_W = 2;
	localparam logic [7:0] RCON_FIRST = 8'h01;
	localparam logic [7:0] POLY = 8'h1b;
	localparam logic [7:0] TOP_BIT = 8'h80;

	typedef struct packed {
		logic start;
	} exp_ctl_t;

	localparam logic [7:0] SBOX [256] = '{
	8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
	8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
	8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
	8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
	8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
	8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
	8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
	8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
	8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
	8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
	8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
	8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
	8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
	8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
	8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
	8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

	function automatic logic [7:0] dbl(input logic [7:0] a);
		dbl = {a[6:0], 1'b0} ^ (((a & TOP_BIT) != 8'h00) ? POLY : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction
endpackage

### rtl/core/aes_ram.sv
// Generic simple dual-port RAM (separate write and read address) with registered read.
module aes_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 30
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/core/aes_keyexp.sv
// Key expansion sequencer: produces one 64-bit round key half per cycle.
module aes_keyexp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [255:0]              key,
	input  aes_pkg::exp_ctl_t         ctl_in,
	output logic                      done,
	output logic                      wr_en,
	output logic [aes_pkg::ADDR_W-1:0] wr_addr,
	output logic [63:0]               wr_data
);
	import aes_pkg::*;

	logic [255:0] win_q;
	logic [ADDR_W-1:0] cnt_q;
	logic [7:0] rc_q;
	logic run_q;
	logic [31:0] w0, w1, t0, t1;

	always_comb begin
		unique case (cnt_q[1:0])
			2'd0: t0 = sub_word({win_q[23:0], win_q[31:24]}) ^ {rc_q, 24'h0};
			2'd2: t0 = sub_word(win_q[31:0]);
			default: t0 = win_q[31:0];
		endcase
		w0 = win_q[255:224] ^ t0;
		t1 = w0;
		w1 = win_q[223:192] ^ t1;
	end

	assign wr_en = run_q;
	assign wr_addr = cnt_q;
	assign wr_data = (cnt_q < ADDR_W'(4)) ? win_q[255:192] : {w0, w1};
	assign done = run_q && (cnt_q == ADDR_W'(STORE_DEPTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			rc_q <= RCON_FIRST;
		end else if (ctl_in.start && !run_q) begin
			run_q <= 1'b1;
			cnt_q <= '0;
			rc_q <= RCON_FIRST;
		end else if (run_q) begin
			cnt_q <= cnt_q + ADDR_W'(1);
			if (done) begin
				run_q <= 1'b0;
			end
			if (cnt_q >= ADDR_W'(4) && cnt_q[1:0] == 2'd1) begin
				rc_q <= dbl(rc_q);
			end
		end
	end

	// Window holds the last eight schedule words; first four steps emit the raw key.
	always_ff @(posedge clk) begin
		if (ctl_in.start && !run_q) begin
			win_q <= key;
		end else if (run_q) begin
			if (cnt_q < ADDR_W'(4)) begin
				win_q <= {win_q[191:0], win_q[255:192]};
			end else begin
				win_q <= {win_q[191:0], w0, w1};
			end
		end
	end
endmodule

### rtl/core/aes_round.sv
// One AES round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
module aes_round (
	input  logic [127:0] state_in,
	input  logic [127:0] rkey,
	input  logic         last,
	output logic [127:0] state_out
);
	import aes_pkg::*;

	logic [7:0] s [16];
	logic [7:0] t [16];
	logic [7:0] m [16];
	logic [7:0] a0, a1, a2, a3, al;

	always_comb begin
		for (int b = 0; b < 16; b++) begin
			s[b] = state_in[127-8*b -: 8];
		end
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[r+4*c] = SBOX[s[r+4*((c+r)%4)]];
			end
		end
		for (int c = 0; c < 4; c++) begin
			a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
			al = a0 ^ a1 ^ a2 ^ a3;
			m[4*c]   = last ? a0 : (a0 ^ al ^ dbl(a0 ^ a1));
			m[4*c+1] = last ? a1 : (a1 ^ al ^ dbl(a1 ^ a2));
			m[4*c+2] = last ? a2 : (a2 ^ al ^ dbl(a2 ^ a3));
			m[4*c+3] = last ? a3 : (a3 ^ al ^ dbl(a3 ^ a0));
		end
		for (int b = 0; b < 16; b++) begin
			state_out[127-8*b -: 8] = m[b] ^ rkey[127-8*b -: 8];
		end
	end
endmodule

### rtl/core/aes256_block_encrypt_top.sv
// Top level of the AES-256 ECB block encryptor.
// One block is taken at a time; after the request is accepted the block makes two reads
// of the 64-bit round key store per round (15 round keys) and then waits in
// the output register until taken, while the next block may already be accepted. After a
// key write, the first block first runs the key expansion, which fills all 30 store entries.
module aes256_block_encrypt_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [aes_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                  cfg_data,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [127:0]                 s_tdata, // plain_hi [63:0], plain_lo [127:64]
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [127:0]                 m_tdata  // cipher_hi [63:0], cipher_lo [127:64]
);
	import aes_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXP = 3'd1;
	localparam logic [2:0] ST_RDH = 3'd2;
	localparam logic [2:0] ST_RDL = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [255:0] key_q;
	logic ready_q;
	logic [2:0] st_q;
	logic [RND_W-1:0] rnd_q;
	logic [127:0] state_q, round_out;
	logic [63:0] khi_q, rdata;
	logic [ADDR_W-1:0] raddr_q;
	logic ex_we, ex_done;
	logic [ADDR_W-1:0] ex_addr;
	logic [63:0] ex_data;
	exp_ctl_t ex_ctl;
	logic acc, out_free, rd_lo_s1;

	assign out_free = !m_tvalid || m_tready;
	assign s_tready = (st_q == ST_IDLE);
	assign acc = s_tvalid && s_tready;
	assign ex_ctl.start = acc && !ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_we) begin
			key_q[255-64*cfg_index -: 64] <= cfg_data;
		end
	end

	aes_keyexp u_kx (.clk, .arst_n, .key(key_q), .ctl_in(ex_ctl), .done(ex_done),
		.wr_en(ex_we), .wr_addr(ex_addr), .wr_data(ex_data));

	aes_ram #(.WIDTH(64), .DEPTH(STORE_DEPTH)) u_ram (.clk, .we(ex_we), .waddr(ex_addr),
		.wdata(ex_data), .raddr(raddr_q), .rdata);

	aes_round u_rnd (.state_in(state_q), .rkey({khi_q, rdata}),
		.last(rnd_q == RND_W'(NUM_ROUNDS)), .state_out(round_out));

	// Reads alternate high/low halves; read data arrives in the cycle after the address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			ready_q <= 1'b0;
			rnd_q <= '0;
			raddr_q <= '0;
			rd_lo_s1 <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			if (cfg_we) begin
				ready_q <= 1'b0;
			end
			rd_lo_s1 <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (acc) begin
						rnd_q <= '0;
						raddr_q <= '0;
						st_q <= ready_q ? ST_RDH : ST_EXP;
					end
				end
				ST_EXP: begin
					if (ex_done) begin
						ready_q <= 1'b1;
						st_q <= ST_RDH;
					end
				end
				ST_RDH: begin
					raddr_q <= raddr_q + ADDR_W'(1);
					st_q <= ST_RDL;
				end
				ST_RDL: begin
					rd_lo_s1 <= 1'b1;
					if (raddr_q != ADDR_W'(STORE_DEPTH - 1)) begin
						raddr_q <= raddr_q + ADDR_W'(1);
						st_q <= ST_RDH;
					end else begin
						st_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!rd_lo_s1 && out_free) begin
						m_tvalid <= 1'b1;
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
			if (rd_lo_s1) begin
				rnd_q <= rnd_q + RND_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			state_q <= {s_tdata[63:0], s_tdata[127:64]};
		end
		if ((st_q == ST_RDL) || (st_q == ST_DONE && rd_lo_s1)) begin
			khi_q <= rdata;
		end
		if (rd_lo_s1) begin
			if (rnd_q == '0) begin
				state_q <= state_q ^ {khi_q, rdata};
			end else begin
				state_q <= round_out;
			end
		end
		if (st_q == ST_DONE && !rd_lo_s1 && out_free) begin
			m_tdata <= {state_q[63:0], state_q[127:64]};
		end
	end

`ifndef SYNTHESIS
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("output changed");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		st_q != ST_IDLE |-> !acc) else $error("accept while busy");
	a_exp_ready: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_RDH |-> ready_q) else $error("read before expansion");
	a_no_write_read: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_RDH || st_q == ST_RDL) |-> !ex_we) else $error("expansion during reads");
`endif
endmodule

### tb/tb.sv
// Self-checking testbench for the AES-256 ECB block encryptor with random flow control.
module tb;
	import aes_pkg::*;

	localparam logic [CFG_IDX_W-1:0] KEY_WORD0 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] KEY_WORD1 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] KEY_WORD2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] KEY_WORD3 = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [127:0] s_tdata = '0; // plain_hi [63:0], plain_lo [127:64]
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [127:0] m_tdata; // cipher_hi [63:0], cipher_lo [127:64]

	logic [63:0] key_reg [4];
	logic [127:0] round_key [NUM_ROUNDS + 1];
	logic [127:0] plain_q [$];
	logic [127:0] cipher_q [$];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int fail_count = 0;
	bit req_taken = 1'b0;

	aes256_block_encrypt_top dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [7:0] gf_double(input logic [7:0] a);
		gf_double = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] sbox_word(input logic [31:0] w);
		sbox_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	function automatic void expand_round_keys();
		logic [31:0] w [4 * (NUM_ROUNDS + 1)];
		logic [31:0] t;
		logic [7:0] rc;
		rc = 8'h01;
		for (int i = 0; i < 4; i++) begin
			w[2 * i] = key_reg[i][63:32];
			w[2 * i + 1] = key_reg[i][31:0];
		end
		for (int i = 8; i < 4 * (NUM_ROUNDS + 1); i++) begin
			t = w[i - 1];
			if (i % 8 == 0) begin
				t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
				rc = gf_double(rc);
			end else if (i % 8 == 4) begin
				t = sbox_word(t);
			end
			w[i] = w[i - 8] ^ t;
		end
		for (int r = 0; r <= NUM_ROUNDS; r++)
			round_key[r] = {w[4 * r], w[4 * r + 1], w[4 * r + 2], w[4 * r + 3]};
	endfunction

	// Byte b of the block sits in bits 127-8b down, byte 0 first.
	function automatic logic [127:0] encrypt_block(input logic [127:0] blk);
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3, x;
		logic [127:0] res;
		for (int b = 0; b < 16; b++)
			s[b] = blk[127 - 8 * b -: 8] ^ round_key[0][127 - 8 * b -: 8];
		for (int r = 1; r <= NUM_ROUNDS; r++) begin
			for (int c = 0; c < 4; c++)
				for (int w = 0; w < 4; w++)
					t[w + 4 * c] = SBOX[s[w + 4 * ((c + w) % 4)]];
			if (r < NUM_ROUNDS) begin
				for (int c = 0; c < 4; c++) begin
					a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
					x = a0 ^ a1 ^ a2 ^ a3;
					t[4 * c] = a0 ^ x ^ gf_double(a0 ^ a1);
					t[4 * c + 1] = a1 ^ x ^ gf_double(a1 ^ a2);
					t[4 * c + 2] = a2 ^ x ^ gf_double(a2 ^ a3);
					t[4 * c + 3] = a3 ^ x ^ gf_double(a3 ^ a0);
				end
			end
			for (int b = 0; b < 16; b++)
				s[b] = t[b] ^ round_key[r][127 - 8 * b -: 8];
		end
		for (int b = 0; b < 16; b++)
			res[127 - 8 * b -: 8] = s[b];
		encrypt_block = res;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("tb: %s mismatch: got %h expected %h", what, got, want);
		fail_count++;
	endtask

	always @(posedge clk) begin
		logic [127:0] want;
		req_taken = s_tvalid && s_tready;
		if (req_taken)
			cipher_q.push_back(encrypt_block({s_tdata[63:0], s_tdata[127:64]}));
		if (m_tvalid && m_tready) begin
			if (cipher_q.size() == 0) begin
				report_mismatch("unexpected cipher_hi", m_tdata[63:0], '0);
			end else begin
				want = cipher_q.pop_front();
				if (m_tdata[63:0] !== want[127:64])
					report_mismatch("cipher_hi", m_tdata[63:0], want[127:64]);
				if (m_tdata[127:64] !== want[63:0])
					report_mismatch("cipher_lo", m_tdata[127:64], want[63:0]);
			end
		end
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
		if (arst_n && (!s_tvalid || req_taken)) begin
			if (plain_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				s_tdata <= plain_q.pop_front();
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	task automatic write_key(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		key_reg[idx] = value;
		expand_round_keys();
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_key(input logic [255:0] k);
		write_key(KEY_WORD0, k[255:192]);
		write_key(KEY_WORD1, k[191:128]);
		write_key(KEY_WORD2, k[127:64]);
		write_key(KEY_WORD3, k[63:0]);
	endtask

	// Plaintext halves: {plain_lo, plain_hi} as packed into tdata.
	task automatic queue_block(input logic [63:0] hi, input logic [63:0] lo);
		plain_q.push_back({lo, hi});
	endtask

	task automatic drain();
		while (plain_q.size() != 0 || s_tvalid || cipher_q.size() != 0)
			@(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	function automatic logic [63:0] random_half();
		case ($urandom_range(9))
			0: random_half = '0;
			1: random_half = '1;
			default: random_half = {$urandom, $urandom};
		endcase
	endfunction

	initial begin
		for (int i = 0; i < 4; i++)
			key_reg[i] = '0;
		expand_round_keys();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// The reset key is all zeros until a key word is written.
		queue_block('0, '0);
		queue_block('1, '1);
		queue_block(64'h0011223344556677, 64'h8899aabbccddeeff);
		drain();

		load_key(256'h000102030405060708090a0b0c0d0e0f101112131415161718191a1b1c1d1e1f);
		queue_block(64'h0011223344556677, 64'h8899aabbccddeeff);
		queue_block('0, '0);
		queue_block('1, '1);
		queue_block('1, '0);
		queue_block('0, '1);
		queue_block(64'h8000000000000000, 64'h0000000000000001);
		drain();

		load_key({256{1'b1}});
		queue_block('0, '0);
		queue_block('1, '1);
		queue_block(64'h0123456789abcdef, 64'hfedcba9876543210);
		drain();

		// A single key word change must redo the whole expansion.
		write_key(KEY_WORD2, 64'h5555aaaa5555aaaa);
		queue_block('0, '0);
		queue_block(64'h0011223344556677, 64'h8899aabbccddeeff);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 82; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 82; end
				default: begin send_idle_pct = 10; recv_stall_pct = 10; end
			endcase
			if (ph == 5)
				write_key(KEY_WORD1, {$urandom, $urandom});
			else
				load_key({$urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom});
			for (int n = 0; n < 155; n++)
				queue_block(random_half(), random_half());
			drain();
		end

		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#4000000;
		$display("tb: failure");
		$finish;
	end
endmodule

### sim.f
rtl/core/aes_pkg.sv
rtl/core/aes_ram.sv
rtl/core/aes_keyexp.sv
rtl/core/aes_round.sv
rtl/core/aes256_block_encrypt_top.sv
tb/tb.sv
